// ===== src/assert_macros.svh =====
// Assertion macros shared by the RTL of the branch predictor
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Check an implication on each clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Check an implication in the cycle after its trigger
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== src/btb_pkg.sv =====
// Shared types and constants of the branch predictor
`timescale 1ns / 1ps
package btb_pkg;

    localparam int unsigned MAX_TAG       = 25;
    localparam int unsigned PC_STEP       = 4;
    localparam int unsigned MID_SHARE_LSB = 16;
    localparam int unsigned LSB_SHARE_LSB = 2;

    typedef enum logic [2:0] {
        CFG_HISTORY_LEN  = 3'd0,
        CFG_TAG_LEN      = 3'd1,
        CFG_INIT_COUNTER = 3'd2,
        CFG_GLOBAL_HIST  = 3'd3,
        CFG_GLOBAL_TABLE = 3'd4,
        CFG_SHARE_MODE   = 3'd5
    } t_cfg_idx;

    typedef enum logic [1:0] {
        SHARE_NONE = 2'd0,
        SHARE_LSB  = 2'd1,
        SHARE_MID  = 2'd2,
        SHARE_ALT  = 2'd3
    } t_share;

    typedef struct packed {
        logic [3:0] history_len;
        logic [4:0] tag_len;
        logic [1:0] initial_counter;
        logic       global_history;
        logic       global_table;
        logic [1:0] share_mode;
    } t_cfg;

    typedef struct packed {
        logic        operation;
        logic [31:0] pc;
        logic [31:0] actual_target;
        logic        actual_taken;
        logic [31:0] predicted_target;
    } t_req;

    typedef struct packed {
        logic        predicted_taken;
        logic [31:0] next_pc;
        logic        flush;
        logic [31:0] branch_count;
        logic [31:0] flush_count;
    } t_rsp;

    typedef struct packed {
        t_req        req;
        logic [24:0] tag;
    } t_dec;

    typedef struct packed {
        logic sweeping;
        logic busy;
    } t_stat;

endpackage

// ===== src/btb_ram.sv =====
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps
module btb_ram #(
    parameter int unsigned WIDTH = 2,
    parameter int unsigned DEPTH = 8192
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and read ports
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== src/btb_front.sv =====
// Front part: tag extraction and request queue towards the back part
`timescale 1ns / 1ps
module btb_front #(
    parameter int unsigned ROW_BITS = 5
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  btb_pkg::t_cfg i_cfg,
    input  logic          i_push,
    input  btb_pkg::t_req i_req,
    input  logic          i_block,
    output logic          o_full,
    output logic          o_head_valid,
    output btb_pkg::t_dec o_head,
    input  logic          i_pop
);
    logic [31:0]    w_shifted;
    logic [4:0]     w_tl;
    logic [25:0]    w_mask;
    btb_pkg::t_dec  w_dec;
    btb_pkg::t_dec  r_mem [2];
    logic           r_wptr;
    logic           r_rptr;
    logic [1:0]     r_count;
    logic           w_push_ok;
    logic           w_pop_ok;

    // Extract the tag bits above the row bits
    always_comb begin
        w_shifted = i_req.pc >> (2 + ROW_BITS);
        w_tl      = (i_cfg.tag_len > 5'(btb_pkg::MAX_TAG)) ? 5'(btb_pkg::MAX_TAG) : i_cfg.tag_len;
        w_mask    = (26'd1 << w_tl) - 26'd1;
        w_dec.req = i_req;
        w_dec.tag = w_shifted[24:0] & w_mask[24:0];
    end

    assign o_full       = (r_count == 2'd2) || i_block;
    assign w_push_ok    = i_push && !o_full;
    assign w_pop_ok     = i_pop && (r_count != 2'd0);
    assign o_head_valid = (r_count != 2'd0);
    assign o_head       = r_mem[r_rptr];

    // Store accepted requests
    always_ff @(posedge i_clk) begin
        if (w_push_ok) begin
            r_mem[r_wptr] <= w_dec;
        end
    end

    // Advance the queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (w_push_ok) begin
                r_wptr <= ~r_wptr;
            end
            if (w_pop_ok) begin
                r_rptr <= ~r_rptr;
            end
            r_count <= r_count + {1'b0, w_push_ok} - {1'b0, w_pop_ok};
        end
    end
endmodule

// ===== src/btb_back.sv =====
// Back part: BTB lookup, counter training, row and full clearing passes and result queue
`timescale 1ns / 1ps
module btb_back #(
    parameter int unsigned ROW_BITS    = 5,
    parameter int unsigned MAX_HISTORY = 8
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  btb_pkg::t_cfg  i_cfg,
    input  logic           i_sweep_start,
    input  logic           i_head_valid,
    input  btb_pkg::t_dec  i_head,
    output logic           o_pop,
    output btb_pkg::t_stat o_stat,
    output logic           o_empty,
    output btb_pkg::t_rsp  o_rsp,
    input  logic           i_rsp_pop
);
    localparam int unsigned RW    = (ROW_BITS > 0) ? ROW_BITS : 1;
    localparam int unsigned NROWS = 2 ** RW;
    localparam int unsigned AW    = RW + MAX_HISTORY;
    localparam int unsigned DEPTH = 2 ** AW;

    typedef enum logic [4:0] {
        S_SWEEP = 5'b00001,
        S_IDLE  = 5'b00010,
        S_CLEAR = 5'b00100,
        S_EXEC  = 5'b01000,
        S_SPARE = 5'b10000
    } t_state;

    t_state                 r_state, n_state;
    logic                   r_valid  [NROWS];
    logic [24:0]            r_tag    [NROWS];
    logic [31:0]            r_target [NROWS];
    logic [MAX_HISTORY-1:0] r_hist   [NROWS];
    logic [MAX_HISTORY-1:0] r_shared;
    logic [31:0]            r_branches;
    logic [31:0]            r_flushes;
    logic [AW-1:0]          r_swp;
    logic [MAX_HISTORY-1:0] r_clr;

    btb_pkg::t_dec          r_item;
    logic [RW-1:0]          r_row;
    logic                   r_hit;
    logic [AW-1:0]          r_slot;
    logic [MAX_HISTORY-1:0] r_heff;
    logic                   r_use_init;

    btb_pkg::t_rsp          r_oq [2];
    logic                   r_oq_w;
    logic                   r_oq_r;
    logic [1:0]             r_oq_cnt;

    logic [RW-1:0]          w_row;
    logic                   w_hit;
    logic [3:0]             w_hb;
    logic [MAX_HISTORY:0]   w_hm_full;
    logic [MAX_HISTORY-1:0] w_hmask;
    logic [MAX_HISTORY-1:0] w_hcur;
    logic [MAX_HISTORY-1:0] w_heff;
    logic [MAX_HISTORY-1:0] w_share;
    logic [MAX_HISTORY-1:0] w_col;
    logic [AW-1:0]          w_slot;
    logic                   w_need_clear;
    logic                   w_take;

    logic                   w_room;
    logic                   w_exec_go;
    logic [1:0]             w_cnt;
    logic [1:0]             w_trained;
    logic                   w_guess;
    logic                   w_flush;
    logic                   w_ptaken;
    logic [MAX_HISTORY-1:0] w_hnew;
    btb_pkg::t_rsp          w_rsp;
    logic                   w_oq_pop;

    logic                   w_we;
    logic [AW-1:0]          w_waddr;
    logic [1:0]             w_wdata;
    logic [1:0]             w_rdata;

    // Classify the head request against the BTB
    always_comb begin
        w_row        = RW'((i_head.req.pc >> 2) & ((32'd1 << ROW_BITS) - 32'd1));
        w_hit        = r_valid[w_row] && (r_tag[w_row] == i_head.tag);
        if (i_cfg.history_len == 4'd0) begin
            w_hb = 4'd1;
        end else if (i_cfg.history_len > 4'(MAX_HISTORY)) begin
            w_hb = 4'(MAX_HISTORY);
        end else begin
            w_hb = i_cfg.history_len;
        end
        w_hm_full    = ((MAX_HISTORY+1)'(1) << w_hb) - (MAX_HISTORY+1)'(1);
        w_hmask      = w_hm_full[MAX_HISTORY-1:0];
        w_hcur       = i_cfg.global_history ? r_shared : r_hist[w_row];
        w_heff       = (i_head.req.operation && !w_hit && !i_cfg.global_history) ?
                       '0 : (w_hcur & w_hmask);
        unique case (btb_pkg::t_share'(i_cfg.share_mode))
            btb_pkg::SHARE_NONE: w_share = '0;
            btb_pkg::SHARE_LSB:  w_share = i_head.req.pc[btb_pkg::LSB_SHARE_LSB +: MAX_HISTORY];
            btb_pkg::SHARE_MID,
            btb_pkg::SHARE_ALT:  w_share = i_head.req.pc[btb_pkg::MID_SHARE_LSB +: MAX_HISTORY];
            default:             w_share = '0;
        endcase
        w_col        = (w_heff ^ w_share) & w_hmask;
        w_slot       = {(i_cfg.global_table ? RW'(0) : w_row), w_col};
        w_need_clear = i_head.req.operation && !w_hit && !i_cfg.global_table;
        w_take       = (r_state == S_IDLE) && i_head_valid && !i_sweep_start;
    end

    assign o_pop = w_take;

    // Compute the result and the training step
    always_comb begin
        w_room    = (r_oq_cnt != 2'd2);
        w_exec_go = (r_state == S_EXEC) && w_room;
        w_cnt     = r_use_init ? i_cfg.initial_counter : w_rdata;
        w_guess   = (w_cnt > 2'd1);
        if (r_item.req.actual_taken) begin
            w_trained = (w_cnt == 2'd3) ? w_cnt : w_cnt + 2'd1;
        end else begin
            w_trained = (w_cnt == 2'd0) ? w_cnt : w_cnt - 2'd1;
        end
        w_ptaken = r_hit && w_guess;
        w_flush  = ((r_hit && (w_guess != r_item.req.actual_taken)) ||
                    (r_item.req.actual_taken &&
                     (r_item.req.predicted_target != r_item.req.actual_target)));
        w_hnew   = MAX_HISTORY'({r_heff, r_item.req.actual_taken}) & w_hmask;
        if (r_item.req.operation) begin
            w_rsp.predicted_taken = 1'b0;
            w_rsp.next_pc         = '0;
            w_rsp.flush           = w_flush;
            w_rsp.branch_count    = r_branches + 32'd1;
            w_rsp.flush_count     = r_flushes + {31'd0, w_flush};
        end else begin
            w_rsp.predicted_taken = w_ptaken;
            w_rsp.next_pc         = w_ptaken ? r_target[r_row] :
                                    r_item.req.pc + 32'(btb_pkg::PC_STEP);
            w_rsp.flush           = 1'b0;
            w_rsp.branch_count    = r_branches;
            w_rsp.flush_count     = r_flushes;
        end
    end

    // Drive the counter RAM write port
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_slot;
        w_wdata = w_trained;
        if (r_state == S_SWEEP) begin
            w_we    = 1'b1;
            w_waddr = r_swp;
            w_wdata = i_cfg.initial_counter;
        end else if (r_state == S_CLEAR) begin
            w_we    = 1'b1;
            w_waddr = {r_row, r_clr};
            w_wdata = i_cfg.initial_counter;
        end else if (w_exec_go && r_item.req.operation) begin
            w_we = 1'b1;
        end
    end

    btb_ram #(
        .WIDTH(2),
        .DEPTH(DEPTH)
    ) u_counters (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_re   (w_take),
        .i_raddr(w_slot),
        .o_rdata(w_rdata)
    );

    // Select the next state
    always_comb begin
        n_state = r_state;
        if (i_sweep_start) begin
            n_state = S_SWEEP;
        end else begin
            unique case (r_state)
                S_SWEEP: if (&r_swp) n_state = S_IDLE;
                S_IDLE:  if (w_take) n_state = w_need_clear ? S_CLEAR : S_EXEC;
                S_CLEAR: if (&r_clr) n_state = S_EXEC;
                S_EXEC:  if (w_room) n_state = S_IDLE;
                default: n_state = S_IDLE;
            endcase
        end
    end

    // Advance the control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_SWEEP;
            r_swp      <= '0;
            r_clr      <= '0;
            r_shared   <= '0;
            r_branches <= '0;
            r_flushes  <= '0;
            for (int i = 0; i < NROWS; i++) begin
                r_valid[i] <= 1'b0;
                r_hist[i]  <= '0;
            end
        end else begin
            r_state <= n_state;
            if (i_sweep_start) begin
                r_swp <= '0;
            end else if (r_state == S_SWEEP) begin
                r_swp <= r_swp + AW'(1);
            end
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + MAX_HISTORY'(1);
            end else begin
                r_clr <= '0;
            end
            if (w_exec_go && r_item.req.operation) begin
                r_branches     <= r_branches + 32'd1;
                r_flushes      <= r_flushes + {31'd0, w_flush};
                r_valid[r_row] <= 1'b1;
                if (i_cfg.global_history) begin
                    r_shared <= w_hnew;
                end else begin
                    r_hist[r_row] <= w_hnew;
                end
            end
        end
    end

    // Hold the request under work and write the BTB entry
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_item     <= i_head;
            r_row      <= w_row;
            r_hit      <= w_hit;
            r_slot     <= w_slot;
            r_heff     <= w_heff;
            r_use_init <= w_need_clear;
        end
        if (w_exec_go && r_item.req.operation) begin
            r_tag[r_row]    <= r_item.tag;
            r_target[r_row] <= r_item.req.actual_target;
        end
        if (w_exec_go) begin
            r_oq[r_oq_w] <= w_rsp;
        end
    end

    // Result queue pointers
    assign w_oq_pop = i_rsp_pop && (r_oq_cnt != 2'd0);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oq_w   <= 1'b0;
            r_oq_r   <= 1'b0;
            r_oq_cnt <= 2'd0;
        end else begin
            if (w_exec_go) begin
                r_oq_w <= ~r_oq_w;
            end
            if (w_oq_pop) begin
                r_oq_r <= ~r_oq_r;
            end
            r_oq_cnt <= r_oq_cnt + {1'b0, w_exec_go} - {1'b0, w_oq_pop};
        end
    end

    assign o_empty         = (r_oq_cnt == 2'd0);
    assign o_rsp           = r_oq[r_oq_r];
    assign o_stat.sweeping = (r_state == S_SWEEP);
    assign o_stat.busy     = (r_state != S_IDLE);
endmodule

// ===== src/btb_two_level_branch_predictor.sv =====
// Each request is taken in IDLE and written to the result queue in EXEC before the next.
// An update that misses with per-entry counter rows clears the row first, writing each
// counter of the row through the single write port of the counter RAM.
// Reset (synchronous, i_rst_n low) and every initial_counter write start a clearing pass
// over all 2^(row bits + MAX_HISTORY) counters of the RAM (8192 by default), full held.
// Queues and BTB valid bits are cleared by reset; histories and totals are zeroed.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module btb_two_level_branch_predictor #(
    parameter int unsigned BTB_ENTRIES = 32,
    parameter int unsigned MAX_HISTORY = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  btb_pkg::t_req i_req,
    output logic          o_full,
    output logic          o_empty,
    input  logic          i_pop,
    output btb_pkg::t_rsp o_rsp,
    input  logic          i_cfg_we,
    input  logic [2:0]    i_cfg_idx,
    input  logic [4:0]    i_cfg_wdata
);
    localparam int unsigned ROW_BITS = $clog2(BTB_ENTRIES + 1) - 1;

    btb_pkg::t_cfg  r_cfg;
    btb_pkg::t_stat w_stat;
    btb_pkg::t_dec  w_head;
    logic           w_head_valid;
    logic           w_head_pop;
    logic           w_sweep_start;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.history_len     <= 4'd2;
            r_cfg.tag_len         <= 5'd8;
            r_cfg.initial_counter <= 2'd1;
            r_cfg.global_history  <= 1'b0;
            r_cfg.global_table    <= 1'b0;
            r_cfg.share_mode      <= 2'd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                btb_pkg::CFG_HISTORY_LEN:  r_cfg.history_len     <= i_cfg_wdata[3:0];
                btb_pkg::CFG_TAG_LEN:      r_cfg.tag_len         <= i_cfg_wdata;
                btb_pkg::CFG_INIT_COUNTER: r_cfg.initial_counter <= i_cfg_wdata[1:0];
                btb_pkg::CFG_GLOBAL_HIST:  r_cfg.global_history  <= i_cfg_wdata[0];
                btb_pkg::CFG_GLOBAL_TABLE: r_cfg.global_table    <= i_cfg_wdata[0];
                btb_pkg::CFG_SHARE_MODE:   r_cfg.share_mode      <= i_cfg_wdata[1:0];
                default: ;
            endcase
        end
    end

    assign w_sweep_start = i_cfg_we && (i_cfg_idx == btb_pkg::CFG_INIT_COUNTER);

    btb_front #(
        .ROW_BITS(ROW_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_push      (i_push),
        .i_req       (i_req),
        .i_block     (w_stat.sweeping),
        .o_full      (o_full),
        .o_head_valid(w_head_valid),
        .o_head      (w_head),
        .i_pop       (w_head_pop)
    );

    btb_back #(
        .ROW_BITS   (ROW_BITS),
        .MAX_HISTORY(MAX_HISTORY)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_sweep_start(w_sweep_start),
        .i_head_valid (w_head_valid),
        .i_head       (w_head),
        .o_pop        (w_head_pop),
        .o_stat       (w_stat),
        .o_empty      (o_empty),
        .o_rsp        (o_rsp),
        .i_rsp_pop    (i_pop)
    );

    // Checks on the predictor control
    `ASSERT_IMPL(a_sweep_blocks, i_clk, i_rst_n, w_stat.sweeping, o_full, "request taken during clearing pass")
    `ASSERT_NEXT(a_init_sweeps, i_clk, i_rst_n, w_sweep_start, o_full && w_stat.sweeping, "initial counter write did not start clearing pass")
    `ASSERT_IMPL(a_reset_empty, i_clk, i_rst_n, !$past(i_rst_n), o_empty, "result pending straight after reset")
endmodule
